@@ rtl/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared types, codes and sizes for the allocator controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  localparam int GRANULES = 4096;
  localparam int IDX_W    = 12;
  localparam int LEN_W    = 13;
  localparam int NEED_W   = 21;
  localparam int SCAN_W   = 14;
  localparam int IN_W     = 64;
  localparam int OUT_W    = 112;

  localparam logic [LEN_W-1:0] HEAP_LEN = LEN_W'(GRANULES);

  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_FREE    = 2'd2,
    OP_REALLOC = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OOM = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  localparam logic REG_HEAP_BASE     = 1'b0;
  localparam logic REG_HEAP_GRANULES = 1'b1;

  typedef struct packed {
    logic             start;
    logic             used;
    logic [LEN_W-1:0] len;
  } entry_t;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_RCLEAR,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_LOC_RD,
    CMD_LOC_EV,
    CMD_SET_BAD,
    CMD_SET_OOM,
    CMD_SHRINK,
    CMD_SPLIT_WR,
    CMD_FIT_RD,
    CMD_FIT_NEXT,
    CMD_FIT_TAKE,
    CMD_REL_RD,
    CMD_REL_EV,
    CMD_BK_RD,
    CMD_BK_MERGE,
    CMD_FW_RD,
    CMD_FW_MERGE,
    CMD_REL_WR,
    CMD_RESULT
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic addr_null;
    logic loc_ok;
    logic rd_start;
    logic rd_used;
    logic rd_len_zero;
    logic fits_need;
    logic fit_split;
    logic shrink_split;
    logic scan_end;
    logic g_zero;
    logic k_zero;
    logic bk_merge;
    logic fw_ok;
    logic clr_last;
    logic out_free;
  } dp_flags_t;

endpackage

`default_nettype wire

@@ rtl/ffa_dp.sv @@
// ----------------------------------------------------------------------------
// First-fit heap allocator datapath
// Block table memory, scan and merge registers, statistics and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_dp (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ffa_pkg::cmd_t             cmd,
  output ffa_pkg::dp_flags_t             flags,
  input  wire logic [ffa_pkg::IN_W-1:0]  s_tdata,
  input  wire logic                      cfg_valid,
  input  wire logic                      cfg_index,
  input  wire logic [31:0]               cfg_data,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [ffa_pkg::OUT_W-1:0]      m_tdata
);

  localparam int IW = ffa_pkg::IDX_W;
  localparam int LW = ffa_pkg::LEN_W;
  localparam int SW = ffa_pkg::SCAN_W;

  ffa_pkg::entry_t mem [ffa_pkg::GRANULES];
  ffa_pkg::entry_t rd_q;

  logic [31:0] heap_base;
  logic [12:0] heap_granules;

  ffa_pkg::op_t               op_q;
  logic [31:0]                addr_q;
  logic [ffa_pkg::NEED_W-1:0] need_q;
  logic [SW-1:0]              i_q;
  logic [IW-1:0]              g_q, k_q, clr_q, split_at_q;
  logic [LW-1:0]              gl_q, split_rem_q;
  logic                       gu_q;
  ffa_pkg::status_t           status_q;
  logic [31:0]                res_addr_q, copy_from_q;
  logic                       copy_needed_q;
  logic [15:0]                copy_bytes_q;
  logic [16:0]                bytes_q;
  logic [11:0]                count_q;

  logic [31:0]   off, offm, pay_g, pay_i;
  logic [IW-1:0] loc_idx;
  logic [LW-1:0] need13, rem_fit, rem_sh, take_len, n_init;
  logic [SW-1:0] at_fit, at_sh, fw_n, bk_sum;
  logic [24:0]   need_sum;

  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  ffa_pkg::entry_t wdata;

  always_comb begin
    off      = addr_q - heap_base;
    offm     = off - 32'd16;
    loc_idx  = offm[15:4];
    pay_g    = heap_base + {16'd0, g_q, 4'd0} + 32'd16;
    pay_i    = heap_base + {16'd0, i_q[IW-1:0], 4'd0} + 32'd16;
    need13   = need_q[LW-1:0];
    rem_fit  = rd_q.len - need13;
    rem_sh   = gl_q - need13;
    at_fit   = i_q + {1'b0, need13};
    at_sh    = {2'd0, g_q} + {1'b0, need13};
    fw_n     = {2'd0, g_q} + {1'b0, gl_q};
    bk_sum   = {2'd0, k_q} + {1'b0, rd_q.len};
    need_sum = {1'b0, s_tdata[57:34]} + 25'd31;
    if (heap_granules < 13'd2) begin
      n_init = 13'd2;
    end else if (heap_granules > ffa_pkg::HEAP_LEN) begin
      n_init = ffa_pkg::HEAP_LEN;
    end else begin
      n_init = heap_granules;
    end

    flags.op           = op_q;
    flags.addr_null    = (addr_q == 32'd0);
    flags.loc_ok       = (off >= 32'd16) && (off[3:0] == 4'd0) && (offm[31:16] == 16'd0);
    flags.rd_start     = rd_q.start;
    flags.rd_used      = rd_q.used;
    flags.rd_len_zero  = (rd_q.len == '0);
    flags.fits_need    = ({8'd0, rd_q.len} >= need_q);
    flags.fit_split    = (rem_fit > 13'd2) && (at_fit < SW'(ffa_pkg::GRANULES));
    flags.shrink_split = (rem_sh > 13'd2) && (at_sh < SW'(ffa_pkg::GRANULES));
    flags.scan_end     = (i_q >= SW'(ffa_pkg::GRANULES));
    flags.g_zero       = (g_q == '0);
    flags.k_zero       = (k_q == '0);
    flags.bk_merge     = rd_q.start && !rd_q.used && (bk_sum == {2'd0, g_q});
    flags.fw_ok        = (gl_q != '0) && (fw_n < SW'(ffa_pkg::GRANULES));
    flags.clr_last     = (clr_q == '1);
    flags.out_free     = !m_tvalid || m_tready;

    take_len = flags.fit_split ? need13 : rd_q.len;
  end

  // Memory port control decoded from the command of this cycle.
  always_comb begin
    we    = 1'b0;
    waddr = g_q;
    wdata = '{start: 1'b1, used: 1'b0, len: gl_q};
    re    = 1'b0;
    raddr = g_q;
    case (cmd)
      ffa_pkg::CMD_RCLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = (clr_q == '0) ?
                ffa_pkg::entry_t'{start: 1'b1, used: 1'b0, len: ffa_pkg::HEAP_LEN} :
                ffa_pkg::entry_t'(0);
      end
      ffa_pkg::CMD_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = (clr_q == '0) ? ffa_pkg::entry_t'{start: 1'b1, used: 1'b0, len: n_init} :
                ffa_pkg::entry_t'(0);
      end
      ffa_pkg::CMD_LOC_RD: begin
        re    = 1'b1;
        raddr = loc_idx;
      end
      ffa_pkg::CMD_SHRINK: begin
        we    = flags.shrink_split;
        wdata = '{start: 1'b1, used: gu_q, len: need13};
      end
      ffa_pkg::CMD_SPLIT_WR: begin
        we    = 1'b1;
        waddr = split_at_q;
        wdata = '{start: 1'b1, used: 1'b0, len: split_rem_q};
      end
      ffa_pkg::CMD_FIT_RD: begin
        re    = 1'b1;
        raddr = i_q[IW-1:0];
      end
      ffa_pkg::CMD_FIT_TAKE: begin
        we    = 1'b1;
        waddr = i_q[IW-1:0];
        wdata = '{start: 1'b1, used: 1'b1, len: take_len};
      end
      ffa_pkg::CMD_REL_RD: begin
        re = 1'b1;
      end
      ffa_pkg::CMD_BK_RD: begin
        re    = 1'b1;
        raddr = k_q - 1'b1;
      end
      ffa_pkg::CMD_BK_MERGE: begin
        we    = 1'b1;
        wdata = '{start: 1'b0, used: 1'b0, len: gl_q};
      end
      ffa_pkg::CMD_FW_RD: begin
        re    = 1'b1;
        raddr = fw_n[IW-1:0];
      end
      ffa_pkg::CMD_FW_MERGE: begin
        we    = 1'b1;
        waddr = fw_n[IW-1:0];
        wdata = '{start: 1'b0, used: rd_q.used, len: rd_q.len};
      end
      ffa_pkg::CMD_REL_WR: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  // Configuration registers and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base     <= 32'd0;
      heap_granules <= ffa_pkg::HEAP_LEN;
      clr_q         <= '0;
      bytes_q       <= '0;
      count_q       <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == ffa_pkg::REG_HEAP_BASE) begin
          heap_base <= cfg_data;
        end else begin
          heap_granules <= cfg_data[12:0];
        end
      end
      // A new result may be loaded in the cycle the old one leaves.
      if (cmd == ffa_pkg::CMD_RESULT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (cmd)
        ffa_pkg::CMD_RCLEAR, ffa_pkg::CMD_CLEAR: begin
          clr_q   <= clr_q + 1'b1;
          bytes_q <= '0;
          count_q <= '0;
        end
        ffa_pkg::CMD_SHRINK: begin
          if (flags.shrink_split && gu_q) begin
            bytes_q <= bytes_q - {rem_sh, 4'd0};
          end
        end
        ffa_pkg::CMD_FIT_TAKE: begin
          bytes_q <= bytes_q + {take_len, 4'd0};
          count_q <= count_q + 1'b1;
        end
        ffa_pkg::CMD_REL_EV: begin
          if (rd_q.used) begin
            bytes_q <= bytes_q - {rd_q.len, 4'd0};
            count_q <= count_q - 1'b1;
          end
        end
        default: begin
          clr_q <= clr_q;
        end
      endcase
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    case (cmd)
      ffa_pkg::CMD_LOAD: begin
        op_q          <= ffa_pkg::op_t'(s_tdata[1:0]);
        addr_q        <= s_tdata[33:2];
        need_q        <= need_sum[24:4];
        i_q           <= '0;
        status_q      <= ffa_pkg::ST_OK;
        res_addr_q    <= '0;
        copy_needed_q <= 1'b0;
        copy_from_q   <= '0;
        copy_bytes_q  <= '0;
      end
      ffa_pkg::CMD_LOC_RD: begin
        g_q <= loc_idx;
      end
      ffa_pkg::CMD_LOC_EV: begin
        gl_q <= rd_q.len;
        gu_q <= rd_q.used;
        i_q  <= '0;
      end
      ffa_pkg::CMD_SET_BAD: begin
        status_q <= ffa_pkg::ST_BAD;
      end
      ffa_pkg::CMD_SET_OOM: begin
        status_q <= ffa_pkg::ST_OOM;
      end
      ffa_pkg::CMD_SHRINK: begin
        res_addr_q  <= pay_g;
        split_at_q  <= at_sh[IW-1:0];
        split_rem_q <= rem_sh;
      end
      ffa_pkg::CMD_FIT_NEXT: begin
        i_q <= i_q + {1'b0, rd_q.len};
      end
      ffa_pkg::CMD_FIT_TAKE: begin
        res_addr_q  <= pay_i;
        split_at_q  <= at_fit[IW-1:0];
        split_rem_q <= rem_fit;
        if (op_q == ffa_pkg::OP_REALLOC) begin
          copy_needed_q <= 1'b1;
          copy_from_q   <= addr_q;
          copy_bytes_q  <= {gl_q[11:0], 4'd0} - 16'd16;
        end
      end
      ffa_pkg::CMD_REL_EV: begin
        gl_q <= rd_q.len;
        k_q  <= g_q;
      end
      ffa_pkg::CMD_BK_RD: begin
        k_q <= k_q - 1'b1;
      end
      ffa_pkg::CMD_BK_MERGE: begin
        gl_q <= gl_q + rd_q.len;
        g_q  <= k_q;
      end
      ffa_pkg::CMD_FW_MERGE: begin
        gl_q <= gl_q + rd_q.len;
      end
      ffa_pkg::CMD_RESULT: begin
        m_tdata <= {count_q, bytes_q, copy_bytes_q, copy_from_q, copy_needed_q,
                    status_q, res_addr_q};
      end
      default: begin
        op_q <= op_q;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/ffa_ctrl.sv @@
// ----------------------------------------------------------------------------
// First-fit heap allocator controller
// Sequences the clear, locate, first-fit, split and release steps.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ffa_pkg::dp_flags_t flags,
  input  wire logic               s_tvalid,
  output logic                    in_ready,
  output ffa_pkg::cmd_t           cmd
);

  typedef enum logic [18:0] {
    S_RCLR      = 19'h00001,
    S_IDLE      = 19'h00002,
    S_DISP      = 19'h00004,
    S_CLEAR     = 19'h00008,
    S_LOC_RD    = 19'h00010,
    S_LOC_EV    = 19'h00020,
    S_SHRINK    = 19'h00040,
    S_SH_SPLIT  = 19'h00080,
    S_FIT_RD    = 19'h00100,
    S_FIT_EV    = 19'h00200,
    S_FIT_SPLIT = 19'h00400,
    S_REL_RD    = 19'h00800,
    S_REL_EV    = 19'h01000,
    S_BK_RD     = 19'h02000,
    S_BK_EV     = 19'h04000,
    S_FW_CHK    = 19'h08000,
    S_FW_EV     = 19'h10000,
    S_REL_WR    = 19'h20000,
    S_DONE      = 19'h40000
  } state_t;

  state_t state, state_next;
  logic   realloc;

  assign in_ready = (state == S_IDLE);
  assign realloc  = (flags.op == ffa_pkg::OP_REALLOC);

  always_comb begin
    state_next = state;
    cmd        = ffa_pkg::CMD_NOP;
    case (state)
      S_RCLR: begin
        cmd = ffa_pkg::CMD_RCLEAR;
        if (flags.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd        = ffa_pkg::CMD_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (flags.op)
          ffa_pkg::OP_INIT:  state_next = S_CLEAR;
          ffa_pkg::OP_ALLOC: state_next = S_FIT_RD;
          ffa_pkg::OP_FREE:  state_next = flags.addr_null ? S_DONE : S_LOC_RD;
          default:           state_next = S_LOC_RD;
        endcase
      end
      S_CLEAR: begin
        cmd = ffa_pkg::CMD_CLEAR;
        if (flags.clr_last) state_next = S_DONE;
      end
      S_LOC_RD: begin
        if (flags.loc_ok) begin
          cmd        = ffa_pkg::CMD_LOC_RD;
          state_next = S_LOC_EV;
        end else begin
          cmd        = ffa_pkg::CMD_SET_BAD;
          state_next = S_DONE;
        end
      end
      S_LOC_EV: begin
        if (!flags.rd_start) begin
          cmd        = ffa_pkg::CMD_SET_BAD;
          state_next = S_DONE;
        end else begin
          cmd = ffa_pkg::CMD_LOC_EV;
          if (!realloc) state_next = S_REL_EV;
          else if (flags.fits_need) state_next = S_SHRINK;
          else state_next = S_FIT_RD;
        end
      end
      S_SHRINK: begin
        cmd        = ffa_pkg::CMD_SHRINK;
        state_next = flags.shrink_split ? S_SH_SPLIT : S_DONE;
      end
      S_SH_SPLIT: begin
        cmd        = ffa_pkg::CMD_SPLIT_WR;
        state_next = S_DONE;
      end
      S_FIT_RD: begin
        if (flags.scan_end) begin
          cmd        = ffa_pkg::CMD_SET_OOM;
          state_next = S_DONE;
        end else begin
          cmd        = ffa_pkg::CMD_FIT_RD;
          state_next = S_FIT_EV;
        end
      end
      S_FIT_EV: begin
        if (!flags.rd_start || flags.rd_len_zero) begin
          cmd        = ffa_pkg::CMD_SET_OOM;
          state_next = S_DONE;
        end else if (!flags.rd_used && flags.fits_need) begin
          cmd = ffa_pkg::CMD_FIT_TAKE;
          if (flags.fit_split) state_next = S_FIT_SPLIT;
          else state_next = realloc ? S_REL_RD : S_DONE;
        end else begin
          cmd        = ffa_pkg::CMD_FIT_NEXT;
          state_next = S_FIT_RD;
        end
      end
      S_FIT_SPLIT: begin
        cmd        = ffa_pkg::CMD_SPLIT_WR;
        state_next = realloc ? S_REL_RD : S_DONE;
      end
      S_REL_RD: begin
        cmd        = ffa_pkg::CMD_REL_RD;
        state_next = S_REL_EV;
      end
      S_REL_EV: begin
        cmd        = ffa_pkg::CMD_REL_EV;
        state_next = flags.g_zero ? S_FW_CHK : S_BK_RD;
      end
      S_BK_RD: begin
        cmd        = ffa_pkg::CMD_BK_RD;
        state_next = S_BK_EV;
      end
      S_BK_EV: begin
        if (flags.rd_start) begin
          if (flags.bk_merge) cmd = ffa_pkg::CMD_BK_MERGE;
          state_next = S_FW_CHK;
        end else begin
          state_next = flags.k_zero ? S_FW_CHK : S_BK_RD;
        end
      end
      S_FW_CHK: begin
        if (flags.fw_ok) begin
          cmd        = ffa_pkg::CMD_FW_RD;
          state_next = S_FW_EV;
        end else begin
          state_next = S_REL_WR;
        end
      end
      S_FW_EV: begin
        if (flags.rd_start && !flags.rd_used) cmd = ffa_pkg::CMD_FW_MERGE;
        state_next = S_REL_WR;
      end
      S_REL_WR: begin
        cmd        = ffa_pkg::CMD_REL_WR;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (flags.out_free) begin
          cmd        = ffa_pkg::CMD_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RCLR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/first_fit_heap_allocator_core.sv @@
// ----------------------------------------------------------------------------
// First-fit heap allocator core
// Allocator for a heap of 16-byte granules with block splitting and merging.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel (op, address, request_bytes) and each one
// produces exactly one result on the m_ channel. Configuration (heap base and
// heap size in granules) is written through the cfg_ channel, which is always
// ready and should only be used while no request is outstanding.
// One request is handled at a time; its duration is set by the walk over
// the single-port block table, where every visited block is read and then evaluated:
//   alloc   : a read of each block ahead of the fit, plus a split write when it splits.
//   free    : locate, release and merge steps, plus a read per granule between the block
//             and the start of its lower neighbour (backward search for that neighbour).
//   realloc : a shrink is done in place; a move is an alloc followed by a free.
//   init    : all 4096 table entries are cleared, one table entry written per cycle.
// After reset the table is swept once and no request is taken until that
// sweep is over. The result sits in an output register, so the
// core goes on to the next request while a result waits; if the receiver
// still stalls when the next result is ready, the core waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // op[1:0], address[33:2], request_bytes[57:34], zero pad[63:58]
  input  wire logic [63:0]  s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // result_address[31:0], status[33:32], copy_needed[34], copy_from[66:35],
  // copy_bytes[82:67], allocated_bytes[99:83], used_blocks[111:100]
  output logic [111:0]      m_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_data
);

  ffa_pkg::cmd_t      cmd;
  ffa_pkg::dp_flags_t flags;

  // Configuration writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .flags    (flags),
    .s_tvalid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  ffa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .flags     (flags),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // The core is busy in the cycle after it takes a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while the previous one was still starting");

  // A result is only loaded when the output register is free.
  a_result_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd == ffa_pkg::CMD_RESULT) |-> (!m_tvalid || m_tready))
    else $error("result overwrote one that was still waiting");

  // Loading a result always presents it in the next cycle.
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (cmd == ffa_pkg::CMD_RESULT) |=> m_tvalid)
    else $error("loaded result was not presented");

  // The status code never takes the unused value.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[33:32] != 2'd3))
    else $error("unused status code on the result");

endmodule

`default_nettype wire
